FILE: rtl/can_transport_segmenter_unit_defines.svh
// Assertion macros used by the top level of the CAN transport segmenter.
`ifndef CAN_TRANSPORT_SEGMENTER_UNIT_DEFINES_SVH
`define CAN_TRANSPORT_SEGMENTER_UNIT_DEFINES_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define CTSU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctsu: same-cycle check failed");

// Antecedent in a cycle implies the consequent in the next cycle.
`define CTSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctsu: next-cycle check failed");

`endif

FILE: rtl/ctsu_pkg.sv
// Shared constants and types of the CAN transport segmenter.
package ctsu_pkg;

  // Field widths.
  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int SEQ_W  = 4;
  localparam int FILL_W = 3;

  // Payload bytes per frame behind the header byte.
  localparam int GROUP_LEN = 7;

  // Frame header bytes.
  localparam logic [7:0] FF_HEAD = 8'h10;
  localparam logic [7:0] CF_HEAD = 8'h20;

  // Default depth of the frame queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One frame as classified by the front end, before header and masking.
  typedef struct packed {
    logic                          first;
    logic [SEQ_W-1:0]              seq;
    logic [FILL_W-1:0]             count;
    logic                          final_f;
    logic [GROUP_LEN-1:0][7:0]     bytes;
  } frame_desc_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: rtl/ctsu_if.sv
// Handshake interfaces for the input words and the output frames.
interface ctsu_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] msg_byte;
  logic       last_byte;

  modport source (output valid, mode, msg_byte, last_byte, input ready);
  modport sink (input valid, mode, msg_byte, last_byte, output ready);
endinterface

interface ctsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [ctsu_pkg::ID_W-1:0]   frame_id;
  logic [ctsu_pkg::LEN_W-1:0]  frame_len;
  logic [7:0]                  byte_0;
  logic [7:0]                  byte_1;
  logic [7:0]                  byte_2;
  logic [7:0]                  byte_3;
  logic [7:0]                  byte_4;
  logic [7:0]                  byte_5;
  logic [7:0]                  byte_6;
  logic [7:0]                  byte_7;
  logic                        final_frame;

  modport source (output valid, frame_id, frame_len, byte_0, byte_1, byte_2, byte_3,
                  byte_4, byte_5, byte_6, byte_7, final_frame, input ready);
  modport sink (input valid, frame_id, frame_len, byte_0, byte_1, byte_2, byte_3,
                byte_4, byte_5, byte_6, byte_7, final_frame, output ready);
endinterface

FILE: rtl/ctsu_front.sv
// Front end: accepts message words, tracks prefix and group counts, builds frames.
module ctsu_front (
  input  logic                   clk,
  input  logic                   rst,
  ctsu_in_if.sink                ingress,
  input  ctsu_pkg::queue_stat_t  qstat,
  output logic                   push,
  output ctsu_pkg::frame_desc_t  desc
);

  logic [7:0]                     store [ctsu_pkg::GROUP_LEN];
  logic [ctsu_pkg::FILL_W-1:0]    skip_count;
  logic [ctsu_pkg::FILL_W-1:0]    group_fill;
  logic [ctsu_pkg::SEQ_W-1:0]     sequence_number;
  logic                           first_sent;

  logic                           accept;
  logic                           in_prefix;
  logic                           store_we;
  logic                           emit_ff;
  logic                           emit_cf;
  logic [ctsu_pkg::FILL_W-1:0]    wr_idx;

  localparam logic [ctsu_pkg::FILL_W-1:0] LAST_SLOT = ctsu_pkg::FILL_W'(ctsu_pkg::GROUP_LEN - 1);
  localparam logic [ctsu_pkg::FILL_W-1:0] PREFIX_DONE = ctsu_pkg::FILL_W'(ctsu_pkg::GROUP_LEN);

  // A word is taken whenever the frame queue has room.
  assign ingress.ready = !qstat.full;
  assign accept        = ingress.valid && ingress.ready;

  // Classify the word against the message position.
  assign in_prefix = (skip_count != PREFIX_DONE);
  assign wr_idx    = in_prefix ? skip_count : group_fill;
  assign store_we  = accept && (in_prefix || !ingress.mode);
  assign emit_ff   = in_prefix && ingress.mode && !first_sent &&
                     ((skip_count == LAST_SLOT) || ingress.last_byte);
  assign emit_cf   = !in_prefix && !ingress.mode &&
                     ((group_fill == LAST_SLOT) || ingress.last_byte);
  assign push      = accept && (emit_ff || emit_cf);

  // Frame descriptor: stored bytes with the current word merged in.
  always_comb begin
    desc.first   = in_prefix;
    desc.seq     = sequence_number;
    desc.count   = wr_idx + 1'b1;
    desc.final_f = ingress.last_byte;
    for (int k = 0; k < ctsu_pkg::GROUP_LEN; k++) begin
      desc.bytes[k] = (wr_idx == ctsu_pkg::FILL_W'(k)) ? ingress.msg_byte : store[k];
    end
  end

  // Payload store, no reset needed.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[wr_idx] <= ingress.msg_byte;
    end
  end

  // Message position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count      <= '0;
      group_fill      <= '0;
      sequence_number <= ctsu_pkg::SEQ_W'(1);
      first_sent      <= 1'b0;
    end else if (accept) begin
      if (ingress.last_byte) begin
        skip_count      <= '0;
        group_fill      <= '0;
        sequence_number <= ctsu_pkg::SEQ_W'(1);
        first_sent      <= 1'b0;
      end else if (in_prefix) begin
        skip_count <= skip_count + 1'b1;
        if (emit_ff) begin
          first_sent <= 1'b1;
        end
      end else if (!ingress.mode) begin
        if (emit_cf) begin
          group_fill      <= '0;
          sequence_number <= sequence_number + 1'b1;
        end else begin
          group_fill <= group_fill + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/ctsu_queue.sv
// Short frame queue that decouples the front end from the output stage.
module ctsu_queue #(
  parameter int DEPTH = ctsu_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ctsu_pkg::frame_desc_t  push_desc,
  input  logic                   pop,
  output ctsu_pkg::frame_desc_t  head,
  output ctsu_pkg::queue_stat_t  qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ctsu_pkg::frame_desc_t  entries [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == CNT_FULL);
  assign qstat.empty = (count == '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ctsu_back.sv
// Back end: forms header, length and zero fill, and holds the output register.
module ctsu_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ctsu_pkg::ID_W-1:0]   frame_id_reg,
  input  ctsu_pkg::frame_desc_t       head,
  input  ctsu_pkg::queue_stat_t       qstat,
  output logic                        pop,
  ctsu_out_if.source                  egress
);

  logic                       out_valid;
  logic [7:0]                 head_byte;
  logic [ctsu_pkg::GROUP_LEN-1:0][7:0] masked;

  // Load a new frame when the register is empty or being drained.
  assign pop          = !qstat.empty && (!out_valid || egress.ready);
  assign egress.valid = out_valid;

  // Header byte and payload with bytes past the length forced to zero.
  always_comb begin
    head_byte = head.first ? ctsu_pkg::FF_HEAD
                           : (ctsu_pkg::CF_HEAD | {4'h0, head.seq});
    for (int k = 0; k < ctsu_pkg::GROUP_LEN; k++) begin
      masked[k] = (ctsu_pkg::FILL_W'(k) < head.count) ? head.bytes[k] : 8'h00;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (egress.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      egress.frame_id    <= frame_id_reg;
      egress.frame_len   <= {1'b0, head.count} + 1'b1;
      egress.byte_0      <= head_byte;
      egress.byte_1      <= masked[0];
      egress.byte_2      <= masked[1];
      egress.byte_3      <= masked[2];
      egress.byte_4      <= masked[3];
      egress.byte_5      <= masked[4];
      egress.byte_6      <= masked[5];
      egress.byte_7      <= masked[6];
      egress.final_frame <= head.final_f;
    end
  end

endmodule

FILE: rtl/can_transport_segmenter_unit.sv
// Top level of the CAN transport segmenter.
// The block takes one message word per clock cycle on ingress and sends 8-byte
// CAN frames on egress: a first frame (header 0x10) in first-frame mode, or
// consecutive frames (header 0x20 plus a 4-bit sequence number starting at 1)
// in consecutive mode, with the identifier from the frame id register on each.
// The frame that an accepted word completes enters the frame queue, and moves
// into the output register once that register is empty or being drained.
// Ingress stalls only while the frame queue is full, which happens when egress
// is held back; with egress ready the rate is one word every cycle.
`include "can_transport_segmenter_unit_defines.svh"

module can_transport_segmenter_unit #(
  parameter int QUEUE_DEPTH = ctsu_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ctsu_pkg::ID_W-1:0]  cfg_data,
  ctsu_in_if.sink                    ingress,
  ctsu_out_if.source                 egress
);

  logic [ctsu_pkg::ID_W-1:0]  frame_id_reg;
  logic                       push;
  logic                       pop;
  ctsu_pkg::frame_desc_t      push_desc;
  ctsu_pkg::frame_desc_t      head;
  ctsu_pkg::queue_stat_t      qstat;

  // Frame identifier register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id_reg <= '0;
    end else if (cfg_we) begin
      frame_id_reg <= cfg_data;
    end
  end

  ctsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .ingress (ingress),
    .qstat   (qstat),
    .push    (push),
    .desc    (push_desc)
  );

  ctsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ctsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_id_reg (frame_id_reg),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .egress       (egress)
  );

  // A full queue must hold off the input side.
  `CTSU_ASSERT_NOW(a_full_blocks_input, clk, rst, qstat.full, !ingress.ready)
  // A frame pushed into the queue is visible in the queue or on egress next cycle.
  `CTSU_ASSERT_NEXT(a_push_visible, clk, rst, push, !qstat.empty || egress.valid)
  // Every frame on egress carries between one and eight bytes.
  `CTSU_ASSERT_NOW(a_len_range, clk, rst, egress.valid,
                   egress.frame_len != 4'd0 && egress.frame_len <= 4'd8)

endmodule

FILE: tb/sv/tb_can_transport_segmenter_unit.sv
// Self-checking testbench of the CAN transport segmenter with a built-in frame predictor.
module tb_can_transport_segmenter_unit;

  // Mode codes carried by each input word.
  localparam logic MODE_FIRST  = 1'b1;
  localparam logic MODE_CONSEC = 1'b0;

  // Receiver hold-off length and the overall run limit.
  localparam int HOLD_CYCLES  = 400;
  localparam int RUN_LIMIT_TU = 2000000;

  typedef enum int {MSG_FIRST, MSG_CONSEC, MSG_MIXED} msg_kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
  } seg_word_t;

  typedef struct packed {
    logic [ctsu_pkg::ID_W-1:0]  id;
    logic [ctsu_pkg::LEN_W-1:0] len;
    logic [0:7][7:0]            octets;
    logic                       last;
  } can_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [ctsu_pkg::ID_W-1:0] cfg_data;

  ctsu_in_if  word_ch ();
  ctsu_out_if frame_ch ();

  can_transport_segmenter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ingress  (word_ch),
    .egress   (frame_ch)
  );

  // Words waiting to be offered, and frames the block still owes.
  seg_word_t  word_queue[$];
  can_frame_t frames_due[$];
  int words_sent     = 0;
  int words_accepted = 0;
  int error_count    = 0;
  int idle_pct       = 7;

  // Receiver hold-off requests; the receiver counts the stretch itself.
  int hold_req   = 0;
  int hold_taken = 0;
  int hold_left  = 0;

  // Predictor state: identifier register and segmentation state of the message.
  logic [ctsu_pkg::ID_W-1:0]  frame_id_cur = '0;
  logic [7:0]                 msg_bytes[ctsu_pkg::GROUP_LEN];
  logic [2:0]                 prefix_seen = '0;
  logic [2:0]                 group_count = '0;
  logic [ctsu_pkg::SEQ_W-1:0] seq_num     = 4'd1;
  logic                       first_done  = 1'b0;

  always #5 clk = ~clk;

  // Assemble one frame from the collected bytes.
  function automatic can_frame_t build_frame(logic [7:0] head, int count, logic last);
    can_frame_t fr;
    fr.id        = frame_id_cur;
    fr.len       = ctsu_pkg::LEN_W'(count + 1);
    fr.octets[0] = head;
    for (int k = 1; k < 8; k++) begin
      fr.octets[k] = (k - 1 < count) ? msg_bytes[k - 1] : 8'h00;
    end
    fr.last = last;
    return fr;
  endfunction

  // Advance the segmentation state by one accepted word and queue any frame it completes.
  function automatic void segment_word(logic first_mode, logic [7:0] octet, logic last);
    can_frame_t fr;
    logic       emit;
    emit = 1'b0;
    if (prefix_seen < ctsu_pkg::GROUP_LEN) begin
      msg_bytes[prefix_seen] = octet;
      prefix_seen++;
      if (first_mode && !first_done && (prefix_seen == ctsu_pkg::GROUP_LEN || last)) begin
        fr = build_frame(ctsu_pkg::FF_HEAD, prefix_seen, last);
        first_done = 1'b1;
        emit = 1'b1;
      end
    end else if (!first_mode) begin
      msg_bytes[group_count] = octet;
      group_count++;
      if (group_count == ctsu_pkg::GROUP_LEN || last) begin
        fr = build_frame(ctsu_pkg::CF_HEAD | 8'(seq_num), group_count, last);
        seq_num++;
        group_count = '0;
        emit = 1'b1;
      end
    end
    if (emit) frames_due.insert(frames_due.size(), fr);
    // The end of a message clears everything except the byte store.
    if (last) begin
      prefix_seen = '0;
      group_count = '0;
      seq_num     = 4'd1;
      first_done  = 1'b0;
    end
  endfunction

  function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      error_count++;
    end
  endfunction

  // Word driver: predicts on each accepted word, then offers the next one.
  always @(posedge clk) begin : word_driver
    seg_word_t w;
    if (rst) begin
      word_ch.valid <= 1'b0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        segment_word(word_ch.mode, word_ch.msg_byte, word_ch.last_byte);
        words_accepted++;
      end
      if (!word_ch.valid || word_ch.ready) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          w = word_queue.pop_front();
          word_ch.valid     <= 1'b1;
          word_ch.mode      <= w.mode;
          word_ch.msg_byte  <= w.data;
          word_ch.last_byte <= w.last;
        end else begin
          word_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: checks each accepted frame and drives ready, with random gaps and hold-offs.
  always @(posedge clk) begin : frame_monitor
    can_frame_t want;
    can_frame_t got;
    if (rst) begin
      frame_ch.ready <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        got.id     = frame_ch.frame_id;
        got.len    = frame_ch.frame_len;
        got.octets = {frame_ch.byte_0, frame_ch.byte_1, frame_ch.byte_2, frame_ch.byte_3,
                      frame_ch.byte_4, frame_ch.byte_5, frame_ch.byte_6, frame_ch.byte_7};
        got.last   = frame_ch.final_frame;
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got id %h len %h bytes %h final %b",
                   $time, got.id, got.len, got.octets, got.last);
          error_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("frame_id", 32'(want.id), 32'(got.id));
          check_field("frame_len", 32'(want.len), 32'(got.len));
          for (int k = 0; k < 8; k++) begin
            check_field($sformatf("byte_%0d", k), 32'(want.octets[k]), 32'(got.octets[k]));
          end
          check_field("final_frame", 32'(want.last), 32'(got.last));
        end
      end
      if (hold_left == 0 && hold_taken != hold_req) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = hold_req;
      end
      if (hold_left != 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic push_word(logic mode, logic [7:0] data, logic last);
    seg_word_t w;
    w = '{mode: mode, data: data, last: last};
    word_queue.insert(word_queue.size(), w);
    words_sent++;
  endtask

  // One message of the given kind with random length and content.
  task automatic queue_message(msg_kind_t kind);
    int   len;
    logic m;
    m = MODE_FIRST;
    case (kind)
      MSG_FIRST: begin
        len = $urandom_range(20, 1);
      end
      MSG_CONSEC: begin
        m = MODE_CONSEC;
        // Now and then a long message, which at the upper lengths wraps the sequence number.
        len = ($urandom_range(11) == 0) ? $urandom_range(140, 100) : $urandom_range(40, 1);
      end
      default: begin
        len = $urandom_range(15, 1);
      end
    endcase
    for (int i = 0; i < len; i++) begin
      if (kind == MSG_MIXED) m = 1'($urandom_range(1));
      push_word(m, 8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Whole messages until about the given number of words is queued.
  task automatic queue_random(int count, bit consec_only);
    int        start_count;
    int        r;
    msg_kind_t kind;
    while (count > 0) begin
      r = $urandom_range(99);
      kind = consec_only ? MSG_CONSEC : (r < 45) ? MSG_FIRST : (r < 90) ? MSG_CONSEC : MSG_MIXED;
      start_count = words_sent;
      queue_message(kind);
      count -= words_sent - start_count;
    end
  endtask

  // Wait until every word is accepted and every frame has come, then let the pipeline drain.
  task automatic wait_idle();
    while (words_accepted != words_sent || frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_id(logic [ctsu_pkg::ID_W-1:0] id);
    wait_idle();
    cfg_we       <= 1'b1;
    cfg_data     <= id;
    frame_id_cur = id;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence: reset, directed messages, then random phases under several identifiers.
  initial begin
    word_ch.valid     = 1'b0;
    word_ch.mode      = MODE_CONSEC;
    word_ch.msg_byte  = 8'h00;
    word_ch.last_byte = 1'b0;
    frame_ch.ready    = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_frame_id('1);
    // First-frame message of a single byte.
    push_word(MODE_FIRST, 8'hFF, 1'b1);
    // First-frame message of exactly seven bytes, ending on the frame.
    for (int i = 0; i < 7; i++) begin
      push_word(MODE_FIRST, (i == 0) ? 8'h00 : (i == 6) ? 8'hFF : 8'($urandom_range(255)),
                i == 6);
    end
    // Consecutive message that ends inside the skipped prefix.
    for (int i = 0; i < 3; i++) push_word(MODE_CONSEC, 8'($urandom_range(255)), i == 2);
    // Consecutive message with a one-byte final group.
    for (int i = 0; i < 8; i++) push_word(MODE_CONSEC, (i == 7) ? 8'hA5 : 8'h5A, i == 7);
    // Mode switched inside the prefix: a consecutive-mode byte, then a short first frame that carries it.
    push_word(MODE_CONSEC, 8'h3C, 1'b0);
    push_word(MODE_FIRST, 8'hC3, 1'b0);
    push_word(MODE_FIRST, 8'h81, 1'b1);

    set_frame_id('0);
    queue_random(450, 1'b0);

    // A stretch with no gaps on either side.
    set_frame_id(ctsu_pkg::ID_W'($urandom));
    idle_pct = 0;
    queue_random(350, 1'b0);

    // Receiver holds off while consecutive frames keep coming, so ingress backs up.
    set_frame_id(ctsu_pkg::ID_W'($urandom));
    idle_pct = 7;
    hold_req++;
    queue_random(300, 1'b1);

    // Sender pauses midway until every frame has come.
    set_frame_id('1);
    queue_random(225, 1'b0);
    wait_idle();
    queue_random(225, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_can_transport_segmenter_unit: PASS");
    end else begin
      $display("tb_can_transport_segmenter_unit: FAIL");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #RUN_LIMIT_TU;
    $display("tb_can_transport_segmenter_unit: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ctsu_pkg.sv
rtl/ctsu_if.sv
rtl/ctsu_front.sv
rtl/ctsu_queue.sv
rtl/ctsu_back.sv
rtl/can_transport_segmenter_unit.sv
tb/sv/tb_can_transport_segmenter_unit.sv
